// ===== design/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types and codes for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_W  = 5;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CFG_W-1:0]         cfg_t;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	localparam word_t MISS_VALUE = 32'hFFFF_FFFF;
	localparam cfg_t  CFG_RESET  = 5'd16;

endpackage

`default_nettype wire

// ===== design/lfu_ram.sv =====
// ----------------------------------------------------------------------------
// LFU entry memory
// Single-port-write, single-port-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 84,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/lfu_cache_lru_tiebreak.sv =====
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// A new request is taken only in idle, after the single pass over the entry
// RAM (one read and, with an update pending, one write-back per entry per
// cycle) and after the last result has left decide, where a stalled output holds it.
// The recency update of a request is folded into the pass of the next one.
// Reset clears valid bits, fill count, pending update and output valid;
// the entry RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_lru_tiebreak #(
	parameter int CAPACITY   = 16,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire lfu_pkg::cfg_t       entries_in_use,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                req_type,
	input  wire lfu_pkg::word_t      key,
	input  wire lfu_pkg::word_t      write_value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     hit,
	output lfu_pkg::word_t           read_value
);

	import lfu_pkg::*;

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int RANK_W = IDX_W;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [COUNT_BITS-1:0] use_t;
	typedef logic [RANK_W-1:0]     rank_t;

	typedef struct packed {
		word_t key;
		word_t value;
		use_t  count;
		rank_t rank;
	} rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t            state_q;
	cnt_t              rd_idx_q;
	logic              vld_s1;
	idx_t              idx_s1;
	logic              out_valid_q;
	logic              hit_q;
	word_t             read_value_q;
	cfg_t              cfg_q;
	cnt_t              filled_q;
	logic [CAPACITY-1:0] valid_q;
	logic              pend_q;

	logic              req_q;
	word_t             key_q;
	word_t             wval_q;

	idx_t              pend_slot_q;
	word_t             pend_key_q;
	word_t             pend_value_q;
	use_t              pend_count_q;
	rank_t             pend_rank_q;
	logic              pend_all_q;

	logic              match_found_q;
	idx_t              match_idx_q;
	word_t             match_value_q;
	use_t              match_count_q;
	rank_t             match_rank_q;
	logic              vic_found_q;
	idx_t              vic_idx_q;
	use_t              vic_count_q;
	rank_t             vic_rank_q;
	logic              free_found_q;
	idx_t              free_idx_q;

	rec_t              rd_rec;
	rec_t              adj_rec;
	logic              rd_en;
	logic              entry_v;
	logic              is_tgt;
	logic              out_free;

	cnt_t              limit;
	logic              dec_pend;
	logic              dec_install;
	logic              dec_grow;
	logic              dec_all;
	idx_t              dec_slot;
	word_t             dec_value;
	use_t              dec_count;
	rank_t             dec_rank;
	word_t             dec_rv;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign rd_en      = (state_q == ST_SCAN) && (rd_idx_q != cnt_t'(CAPACITY));

	lfu_ram #(
		.DEPTH  (CAPACITY),
		.WIDTH  ($bits(rec_t)),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (rd_rec),
		.wr_en   (vld_s1 && pend_q),
		.wr_addr (idx_s1),
		.wr_data (adj_rec)
	);

	// apply the pending update of the previous request to the entry read back
	always_comb begin
		entry_v = valid_q[idx_s1];
		is_tgt  = pend_q && (idx_s1 == pend_slot_q);
		adj_rec = rd_rec;
		if (is_tgt) begin
			adj_rec.key   = pend_key_q;
			adj_rec.value = pend_value_q;
			adj_rec.count = pend_count_q;
			adj_rec.rank  = '0;
		end else if (pend_q && entry_v && (pend_all_q || (rd_rec.rank < pend_rank_q))) begin
			adj_rec.rank = rd_rec.rank + rank_t'(1);
		end
	end

	always_comb begin
		if ({27'd0, cfg_q} > CAPACITY) begin
			limit = cnt_t'(CAPACITY);
		end else begin
			limit = cnt_t'(cfg_q);
		end
		dec_pend    = 1'b0;
		dec_install = 1'b0;
		dec_grow    = 1'b0;
		dec_all     = 1'b0;
		dec_slot    = match_idx_q;
		dec_value   = match_value_q;
		dec_count   = (&match_count_q) ? match_count_q : match_count_q + use_t'(1);
		dec_rank    = match_rank_q;
		dec_rv      = MISS_VALUE;
		if (req_q == REQ_GET) begin
			if (match_found_q) begin
				dec_rv   = match_value_q;
				dec_pend = 1'b1;
			end
		end else if (limit != '0) begin
			if (match_found_q) begin
				dec_pend  = 1'b1;
				dec_value = wval_q;
			end else begin
				dec_value = wval_q;
				dec_count = use_t'(1);
				if (filled_q >= limit) begin
					dec_slot    = vic_idx_q;
					dec_rank    = vic_rank_q;
					dec_pend    = vic_found_q;
					dec_install = vic_found_q;
				end else begin
					dec_slot    = free_idx_q;
					dec_all     = 1'b1;
					dec_pend    = free_found_q;
					dec_install = free_found_q;
					dec_grow    = free_found_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			read_value_q <= MISS_VALUE;
			cfg_q        <= CFG_RESET;
			filled_q     <= '0;
			valid_q      <= '0;
			pend_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= entries_in_use;
			end
			if ((state_q == ST_DECIDE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + cnt_t'(1);
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						hit_q        <= match_found_q;
						read_value_q <= dec_rv;
						pend_q       <= dec_pend;
						if (dec_install) begin
							valid_q[dec_slot] <= 1'b1;
						end
						if (dec_grow) begin
							filled_q <= filled_q + cnt_t'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if ((state_q == ST_IDLE) && in_valid) begin
			req_q         <= req_type;
			key_q         <= key;
			wval_q        <= write_value;
			match_found_q <= 1'b0;
			vic_found_q   <= 1'b0;
			free_found_q  <= 1'b0;
		end
		if (vld_s1) begin
			if (entry_v && (adj_rec.key == key_q)) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
				match_value_q <= adj_rec.value;
				match_count_q <= adj_rec.count;
				match_rank_q  <= adj_rec.rank;
			end
			if (entry_v && (!vic_found_q || (adj_rec.count < vic_count_q) ||
					((adj_rec.count == vic_count_q) && (adj_rec.rank > vic_rank_q)))) begin
				vic_found_q <= 1'b1;
				vic_idx_q   <= idx_s1;
				vic_count_q <= adj_rec.count;
				vic_rank_q  <= adj_rec.rank;
			end
			if (!entry_v && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
		if ((state_q == ST_DECIDE) && out_free) begin
			pend_slot_q  <= dec_slot;
			pend_key_q   <= key_q;
			pend_value_q <= dec_value;
			pend_count_q <= dec_count;
			pend_rank_q  <= dec_rank;
			pend_all_q   <= dec_all;
		end
	end

endmodule

`default_nettype wire
